>>> rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, codes and the result-forming function of the ModRM/SIB
// displacement decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Decoder phase, one-hot coded.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SIB  = 3'b010,
    PH_DISP = 3'b100
  } phase_e;

  // Field codes of the ModRM and SIB bytes.
  localparam logic [1:0] MOD_MEM_NODISP = 2'b00;
  localparam logic [1:0] MOD_MEM_DISP8  = 2'b01;
  localparam logic [1:0] MOD_MEM_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG        = 2'b11;
  localparam logic [2:0] RM_SIB         = 3'b100;
  localparam logic [2:0] BASE_NONE      = 3'b101;
  localparam logic [3:0] INDEX_NONE     = 4'b0100;

  // Displacement byte counts.
  localparam logic [2:0] DISP8_BYTES  = 3'd1;
  localparam logic [2:0] DISP32_BYTES = 3'd4;

  // One decoded operand.
  typedef struct packed {
    logic        is_memory;
    logic [4:0]  reg_field;
    logic [3:0]  rm_or_base;
    logic        has_base;
    logic [3:0]  index_reg;
    logic        has_index;
    logic [1:0]  scale_shift;
    logic [31:0] displacement;
    logic [2:0]  byte_length;
  } result_t;

  // Forms the result from the latched bytes. The rex bits are ordered
  // {present, R, X, B}.
  function automatic result_t build_result(
    input logic [7:0]  modrm,
    input logic [7:0]  sib,
    input logic [3:0]  rex,
    input logic [31:0] disp,
    input logic        disp_is_byte,
    input logic [2:0]  taken
  );
    result_t    r;
    logic [2:0] base3;
    logic [3:0] idx;
    r = '0;
    base3 = modrm[2:0];
    idx = {rex[1], sib[5:3]};
    r.is_memory = (modrm[7:6] != MOD_REG);
    r.reg_field = {rex[3], rex[2], modrm[5:3]};
    r.byte_length = taken;
    if (!r.is_memory) begin
      r.rm_or_base = {rex[0], modrm[2:0]};
    end else begin
      if (modrm[2:0] == RM_SIB) begin
        r.scale_shift = sib[7:6];
        base3 = sib[2:0];
        if (idx != INDEX_NONE) begin
          r.index_reg = idx;
          r.has_index = 1'b1;
        end
      end
      if (!(modrm[7:6] == MOD_MEM_NODISP && base3 == BASE_NONE)) begin
        r.rm_or_base = {rex[0], base3};
        r.has_base = 1'b1;
      end
      r.displacement = disp;
      if (disp_is_byte && disp[7]) begin
        r.displacement[31:8] = '1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/msd_if.sv
// ----------------------------------------------------------------------------
// msd_if
// Valid/ready channels of the decoder: instruction bytes in, operands out.
// ----------------------------------------------------------------------------

// Instruction byte channel.
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       rex_present;
  logic       rex_r;
  logic       rex_x;
  logic       rex_b;

  modport source (output valid, data_byte, first, rex_present, rex_r, rex_x, rex_b,
                  input ready);
  modport sink (input valid, data_byte, first, rex_present, rex_r, rex_x, rex_b,
                output ready);
endinterface

// Decoded operand channel.
interface msd_out_if;
  logic        valid;
  logic        ready;
  logic        is_memory;
  logic [4:0]  reg_field;
  logic [3:0]  rm_or_base;
  logic        has_base;
  logic [3:0]  index_reg;
  logic        has_index;
  logic [1:0]  scale_shift;
  logic [31:0] displacement;
  logic [2:0]  byte_length;

  modport source (output valid, is_memory, reg_field, rm_or_base, has_base, index_reg,
                  has_index, scale_shift, displacement, byte_length,
                  input ready);
  modport sink (input valid, is_memory, reg_field, rm_or_base, has_base, index_reg,
                has_index, scale_shift, displacement, byte_length,
                output ready);
endinterface

>>> rtl/msd_core.sv
// ----------------------------------------------------------------------------
// msd_core
// Decode state: latches ModRM, SIB, REX and displacement bytes and flags
// the byte that completes an operand, together with the formed result.
// ----------------------------------------------------------------------------
module msd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_i,
  input  logic [3:0]        rex_i,
  output logic              emit_o,
  output msd_pkg::result_t  result_o
);

  msd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [7:0]  sib_q, sib_d;
  logic [3:0]  rex_q, rex_d;
  logic [31:0] disp_q, disp_d;
  logic [2:0]  left_q, left_d;
  logic        is_byte_q, is_byte_d;
  logic [2:0]  taken_q, taken_d;
  logic        emit;

  // Next-state logic for one accepted byte.
  always_comb begin
    logic       go_addr;
    logic [2:0] base3;
    logic [2:0] left;
    logic [1:0] lane;
    phase_d   = phase_q;
    modrm_d   = modrm_q;
    sib_d     = sib_q;
    rex_d     = rex_q;
    disp_d    = disp_q;
    left_d    = left_q;
    is_byte_d = is_byte_q;
    taken_d   = taken_q;
    emit      = 1'b0;
    go_addr   = 1'b0;
    base3     = data_byte_i[2:0];
    left      = left_q;
    lane      = '0;

    if (first_i) begin
      // A ModRM byte always restarts decoding.
      modrm_d   = data_byte_i;
      sib_d     = '0;
      rex_d     = rex_i;
      disp_d    = '0;
      left_d    = '0;
      is_byte_d = 1'b0;
      taken_d   = 3'd1;
      if (data_byte_i[7:6] == msd_pkg::MOD_REG) begin
        emit    = 1'b1;
        phase_d = msd_pkg::PH_IDLE;
      end else if (data_byte_i[2:0] == msd_pkg::RM_SIB) begin
        phase_d = msd_pkg::PH_SIB;
      end else begin
        go_addr = 1'b1;
      end
    end else begin
      case (phase_q)
        msd_pkg::PH_SIB: begin
          sib_d   = data_byte_i;
          taken_d = taken_q + 3'd1;
          go_addr = 1'b1;
        end
        msd_pkg::PH_DISP: begin
          // Displacement bytes arrive little-endian.
          if (left_q == 3'd0 || left_q > msd_pkg::DISP32_BYTES) begin
            left = 3'd1;
          end
          lane    = is_byte_q ? 2'd0 : 2'(msd_pkg::DISP32_BYTES - left);
          disp_d  = disp_q | ({24'd0, data_byte_i} << {lane, 3'b000});
          taken_d = taken_q + 3'd1;
          left_d  = left - 3'd1;
          if (left_d == 3'd0) begin
            emit    = 1'b1;
            phase_d = msd_pkg::PH_IDLE;
          end
        end
        default: begin
          // Stray byte while idle, or an unused phase code.
          phase_d = msd_pkg::PH_IDLE;
        end
      endcase
    end

    // Address bytes done: pick the displacement size.
    if (go_addr) begin
      disp_d    = '0;
      is_byte_d = 1'b0;
      if (modrm_d[7:6] == msd_pkg::MOD_MEM_DISP8) begin
        left_d    = msd_pkg::DISP8_BYTES;
        is_byte_d = 1'b1;
        phase_d   = msd_pkg::PH_DISP;
      end else if (modrm_d[7:6] == msd_pkg::MOD_MEM_DISP32 ||
                   (modrm_d[7:6] == msd_pkg::MOD_MEM_NODISP &&
                    base3 == msd_pkg::BASE_NONE)) begin
        left_d  = msd_pkg::DISP32_BYTES;
        phase_d = msd_pkg::PH_DISP;
      end else begin
        left_d  = '0;
        emit    = 1'b1;
        phase_d = msd_pkg::PH_IDLE;
      end
    end
  end

  // State registers, updated on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= msd_pkg::PH_IDLE;
      modrm_q   <= '0;
      sib_q     <= '0;
      rex_q     <= '0;
      disp_q    <= '0;
      left_q    <= '0;
      is_byte_q <= 1'b0;
      taken_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      modrm_q   <= modrm_d;
      sib_q     <= sib_d;
      rex_q     <= rex_d;
      disp_q    <= disp_d;
      left_q    <= left_d;
      is_byte_q <= is_byte_d;
      taken_q   <= taken_d;
    end
  end

  assign emit_o   = accept_i && emit;
  assign result_o = msd_pkg::build_result(modrm_d, sib_d, rex_d, disp_d, is_byte_d,
                                          taken_d);

endmodule

>>> rtl/msd_out_reg.sv
// ----------------------------------------------------------------------------
// msd_out_reg
// Result register: holds one operand until the sink takes it and tells the
// input side when a new byte may be taken.
// ----------------------------------------------------------------------------
module msd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  msd_pkg::result_t result_i,
  input  logic             ready_i,
  output logic             valid_o,
  output msd_pkg::result_t result_o,
  output logic             space_o
);

  logic             valid_q;
  msd_pkg::result_t data_q;

  // Room for a new result when empty or when the held one leaves now.
  assign space_o = !valid_q || ready_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

>>> rtl/x86_modrm_sib_decoder.sv
// ----------------------------------------------------------------------------
// x86_modrm_sib_decoder
// The result of an operand is registered: it is valid in the cycle after the transfer of its last byte.
// One byte per cycle while the result register has space; the result register lets the
// next byte be taken in the same cycle as the held result is transferred.
// Reset (rst_ni, asynchronous, active low) returns decoding to idle and
// empties the result register.
// ----------------------------------------------------------------------------
module x86_modrm_sib_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  msd_in_if.sink     in_i,
  msd_out_if.source  out_o
);

  logic             accept;
  logic             space;
  logic             emit;
  msd_pkg::result_t result;
  msd_pkg::result_t held;

  // A byte is taken whenever the result register can take what it produces.
  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  // Decode state.
  msd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .first_i     (in_i.first),
    .rex_i       ({in_i.rex_present, in_i.rex_r, in_i.rex_x, in_i.rex_b}),
    .emit_o      (emit),
    .result_o    (result)
  );

  // Result register.
  msd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (result),
    .ready_i  (out_o.ready),
    .valid_o  (out_o.valid),
    .result_o (held),
    .space_o  (space)
  );

  // Output payload.
  assign out_o.is_memory    = held.is_memory;
  assign out_o.reg_field    = held.reg_field;
  assign out_o.rm_or_base   = held.rm_or_base;
  assign out_o.has_base     = held.has_base;
  assign out_o.index_reg    = held.index_reg;
  assign out_o.has_index    = held.has_index;
  assign out_o.scale_shift  = held.scale_shift;
  assign out_o.displacement = held.displacement;
  assign out_o.byte_length  = held.byte_length;

endmodule

>>> sim/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker
// Watches both channels of the ModRM/SIB decoder. It keeps its own copy of
// the decode state, works out the operand that each byte transfer completes,
// and compares every operand transfer with the oldest outstanding operand.
// ----------------------------------------------------------------------------
module msd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  msd_in_if    in_mon,
  msd_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Decode state of the predictor.
  msd_pkg::phase_e dec_phase;
  logic [7:0]  modrm_q;
  logic [7:0]  sib_q;
  logic [3:0]  rex_q;          // {present, R, X, B}
  logic [31:0] disp_q;
  logic [2:0]  disp_left_q;
  logic        disp_is_byte_q;
  logic [2:0]  taken_q;

  msd_pkg::result_t expected_operands[$];
  msd_pkg::result_t got_op;
  msd_pkg::result_t want_op;
  int               mismatches;

  // Forms the operand from the latched bytes.
  function automatic msd_pkg::result_t form_operand();
    msd_pkg::result_t op;
    logic [2:0]       base_bits;
    logic [3:0]       index_bits;
    op = '0;
    op.reg_field   = {rex_q[3:2], modrm_q[5:3]};
    op.byte_length = taken_q;
    if (modrm_q[7:6] == msd_pkg::MOD_REG) begin
      op.rm_or_base = {rex_q[0], modrm_q[2:0]};
    end else begin
      op.is_memory = 1'b1;
      base_bits = modrm_q[2:0];
      if (modrm_q[2:0] == msd_pkg::RM_SIB) begin
        base_bits      = sib_q[2:0];
        index_bits     = {rex_q[1], sib_q[5:3]};
        op.scale_shift = sib_q[7:6];
        if (index_bits != msd_pkg::INDEX_NONE) begin
          op.index_reg = index_bits;
          op.has_index = 1'b1;
        end
      end
      // The no-base test looks at the three encoded bits only.
      if (!(modrm_q[7:6] == msd_pkg::MOD_MEM_NODISP &&
            base_bits == msd_pkg::BASE_NONE)) begin
        op.rm_or_base = {rex_q[0], base_bits};
        op.has_base   = 1'b1;
      end
      op.displacement = disp_is_byte_q ? {{24{disp_q[7]}}, disp_q[7:0]} : disp_q;
    end
    return op;
  endfunction

  // Picks the displacement size once the address bytes are in; completes the
  // operand when there is no displacement.
  task automatic start_displacement(input logic [2:0] base_bits);
    disp_q         = '0;
    disp_is_byte_q = 1'b0;
    if (modrm_q[7:6] == msd_pkg::MOD_MEM_DISP8) begin
      disp_left_q    = msd_pkg::DISP8_BYTES;
      disp_is_byte_q = 1'b1;
      dec_phase      = msd_pkg::PH_DISP;
    end else if (modrm_q[7:6] == msd_pkg::MOD_MEM_DISP32 ||
                 (modrm_q[7:6] == msd_pkg::MOD_MEM_NODISP &&
                  base_bits == msd_pkg::BASE_NONE)) begin
      disp_left_q = msd_pkg::DISP32_BYTES;
      dec_phase   = msd_pkg::PH_DISP;
    end else begin
      disp_left_q = '0;
      expected_operands.push_back(form_operand());
      dec_phase = msd_pkg::PH_IDLE;
    end
  endtask

  // Advances the predictor by one transferred byte.
  task automatic decode_byte(input logic [7:0] b, input logic is_first,
                             input logic [3:0] rex);
    logic [2:0] left_now;
    int         shift;
    if (is_first) begin
      // A marked byte always restarts, dropping any operand in progress.
      modrm_q        = b;
      sib_q          = '0;
      rex_q          = rex;
      disp_q         = '0;
      disp_left_q    = '0;
      disp_is_byte_q = 1'b0;
      taken_q        = 3'd1;
      if (b[7:6] == msd_pkg::MOD_REG) begin
        expected_operands.push_back(form_operand());
        dec_phase = msd_pkg::PH_IDLE;
      end else if (b[2:0] == msd_pkg::RM_SIB) begin
        dec_phase = msd_pkg::PH_SIB;
      end else begin
        start_displacement(b[2:0]);
      end
    end else if (dec_phase == msd_pkg::PH_SIB) begin
      sib_q   = b;
      taken_q = taken_q + 3'd1;
      start_displacement(b[2:0]);
    end else if (dec_phase == msd_pkg::PH_DISP) begin
      // Displacement bytes arrive least significant first.
      left_now = disp_left_q;
      if (left_now == 3'd0 || left_now > 3'd4) left_now = 3'd1;
      shift = disp_is_byte_q ? 0 : (4 - int'(left_now)) * 8;
      disp_q      = disp_q | (32'(b) << shift);
      taken_q     = taken_q + 3'd1;
      disp_left_q = left_now - 3'd1;
      if (disp_left_q == 3'd0) begin
        expected_operands.push_back(form_operand());
        dec_phase = msd_pkg::PH_IDLE;
      end
    end else begin
      // Unmarked byte while idle: ignored.
      dec_phase = msd_pkg::PH_IDLE;
    end
  endtask

  function automatic string describe(input msd_pkg::result_t op);
    return $sformatf("mem=%0b reg=%h base=%h/%0b index=%h/%0b scale=%0d disp=%h len=%0d",
                     op.is_memory, op.reg_field, op.rm_or_base, op.has_base,
                     op.index_reg, op.has_index, op.scale_shift, op.displacement,
                     op.byte_length);
  endfunction

  // Compare operand transfers first, then predict from the byte transfer of
  // the same edge; a byte never completes an operand in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_phase      = msd_pkg::PH_IDLE;
      modrm_q        = '0;
      sib_q          = '0;
      rex_q          = '0;
      disp_q         = '0;
      disp_left_q    = '0;
      disp_is_byte_q = 1'b0;
      taken_q        = '0;
      mismatches     = 0;
      expected_operands.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got_op.is_memory    = out_mon.is_memory;
        got_op.reg_field    = out_mon.reg_field;
        got_op.rm_or_base   = out_mon.rm_or_base;
        got_op.has_base     = out_mon.has_base;
        got_op.index_reg    = out_mon.index_reg;
        got_op.has_index    = out_mon.has_index;
        got_op.scale_shift  = out_mon.scale_shift;
        got_op.displacement = out_mon.displacement;
        got_op.byte_length  = out_mon.byte_length;
        if (expected_operands.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected operand: %s", describe(got_op));
        end else begin
          want_op = expected_operands.pop_front();
          if (got_op !== want_op) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("operand mismatch, expected %s", describe(want_op));
              $display("                  actual   %s", describe(got_op));
            end
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        decode_byte(in_mon.data_byte, in_mon.first,
                    {in_mon.rex_present, in_mon.rex_r, in_mon.rex_x, in_mon.rex_b});
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_operands.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction bytes into the ModRM/SIB decoder: a directed set of
// encodings first, then random operands, truncated operands and stray
// bytes, with random gaps on the byte side and random back-pressure on the
// operand side. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   bytes_sent;
  bit   steady;

  msd_in_if  bytes_if ();
  msd_out_if ops_if ();

  x86_modrm_sib_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bytes_if),
    .out_o  (ops_if)
  );

  msd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (bytes_if),
    .out_mon      (ops_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Gap before a byte: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Number of bytes in a complete operand.
  function automatic int operand_length(input logic [7:0] modrm, input logic [7:0] sib);
    logic [2:0] base_bits;
    int         n;
    if (modrm[7:6] == msd_pkg::MOD_REG) return 1;
    n = 1;
    base_bits = modrm[2:0];
    if (modrm[2:0] == msd_pkg::RM_SIB) begin
      n++;
      base_bits = sib[2:0];
    end
    if (modrm[7:6] == msd_pkg::MOD_MEM_DISP8) n += 1;
    else if (modrm[7:6] == msd_pkg::MOD_MEM_DISP32 ||
             base_bits == msd_pkg::BASE_NONE) n += 4;
    return n;
  endfunction

  // Offers one byte and waits for its transfer. Called at a rising edge and
  // returns at the edge of the transfer.
  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic [3:0] rex);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    bytes_if.valid       <= 1'b1;
    bytes_if.data_byte   <= b;
    bytes_if.first       <= is_first;
    bytes_if.rex_present <= rex[3];
    bytes_if.rex_r       <= rex[2];
    bytes_if.rex_x       <= rex[1];
    bytes_if.rex_b       <= rex[0];
    do @(posedge clk_i); while (bytes_if.ready !== 1'b1);
  endtask

  // Sends an operand; a nonzero cut below its length stops after that many bytes. REX bits on
  // the later bytes are random, since the block must ignore them.
  task automatic send_operand(input logic [7:0] modrm, input logic [7:0] sib,
                              input logic [3:0] rex, input logic [31:0] disp,
                              input int cut);
    int         len;
    int         n;
    int         dk;
    bit         sib_used;
    logic [7:0] b;
    len = operand_length(modrm, sib);
    n = (cut > 0 && cut < len) ? cut : len;
    sib_used = (modrm[7:6] != msd_pkg::MOD_REG) && (modrm[2:0] == msd_pkg::RM_SIB);
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        send_byte(modrm, 1'b1, rex);
      end else begin
        if (sib_used && k == 1) begin
          b = sib;
        end else begin
          dk = k - 1 - int'(sib_used);
          b = disp[8*dk +: 8];
        end
        send_byte(b, 1'b0, 4'($urandom));
      end
    end
    bytes_sent += n;
  endtask

  // Random operand, biased toward SIB forms and the no-base encodings.
  task automatic random_operand(input int cut);
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    int          r;
    modrm = 8'($urandom);
    sib   = 8'($urandom);
    disp  = $urandom;
    r = $urandom_range(0, 9);
    if (r < 3) modrm[2:0] = msd_pkg::RM_SIB;
    if (r == 3) sib[2:0] = msd_pkg::BASE_NONE;
    if (r == 4) modrm[2:0] = msd_pkg::BASE_NONE;
    r = $urandom_range(0, 9);
    if (r == 0) disp = 32'h0000_0000;
    else if (r == 1) disp = 32'hFFFF_FFFF;
    else if (r == 2) disp = 32'h0000_0080;
    else if (r == 3) disp = 32'h0000_007F;
    send_operand(modrm, sib, 4'($urandom), disp, cut);
  endtask

  // Operand receiver: random back-pressure, plus one long hold-off so that
  // the block fills up and stalls the byte side.
  initial begin : receiver
    int stretch;
    int cycles;
    int r;
    stretch = 0;
    cycles  = 0;
    ops_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= 1000 && cycles < 1400) begin
        ops_if.ready <= 1'b0;
      end else if (stretch > 0) begin
        stretch--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          ops_if.ready <= 1'b1;
          stretch = $urandom_range(0, 19);
        end else if (r < 85) begin
          ops_if.ready <= 1'b0;
          stretch = $urandom_range(0, 2);
        end else if (r < 97) begin
          ops_if.ready <= 1'b0;
          stretch = $urandom_range(3, 11);
        end else begin
          ops_if.ready <= 1'b0;
          stretch = $urandom_range(19, 59);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int r;
    steady     = 1'b0;
    bytes_sent = 0;
    rst_ni               <= 1'b0;
    bytes_if.valid       <= 1'b0;
    bytes_if.data_byte   <= '0;
    bytes_if.first       <= 1'b0;
    bytes_if.rex_present <= 1'b0;
    bytes_if.rex_r       <= 1'b0;
    bytes_if.rex_x       <= 1'b0;
    bytes_if.rex_b       <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register forms with all and none of the extension bits.
    send_operand(8'hFF, 8'h00, 4'b1111, 32'h0, 0);
    send_operand(8'hC0, 8'h00, 4'b0000, 32'h0, 0);
    // Memory forms without SIB: no displacement, absolute disp32 with REX.B
    // set, negative and positive disp8, disp32.
    send_operand(8'h00, 8'h00, 4'b1000, 32'h0, 0);
    send_operand(8'h3D, 8'h00, 4'b1111, 32'hFFFF_FFFF, 0);
    send_operand(8'h43, 8'h00, 4'b0001, 32'h0000_0080, 0);
    send_operand(8'h4D, 8'h00, 4'b0000, 32'h0000_007F, 0);
    send_operand(8'hB6, 8'h00, 4'b0101, 32'h1234_5678, 0);
    // SIB forms: no base and no index, index 100 extended by REX.X, frame
    // base with disp8, all-zero SIB, SIB chosen although REX.B is set.
    send_operand(8'h04, 8'hE5, 4'b0000, 32'hDEAD_BEEF, 0);
    send_operand(8'h0C, 8'h25, 4'b0010, 32'h0000_0000, 0);
    send_operand(8'h44, 8'h65, 4'b1001, 32'h0000_00FF, 0);
    send_operand(8'h84, 8'h00, 4'b0000, 32'h0000_0000, 0);
    send_operand(8'h24, 8'h1C, 4'b1111, 32'h0000_0000, 0);
    // Restarts in the SIB phase and in both displacement widths.
    send_operand(8'h44, 8'h00, 4'b0000, 32'h0, 1);
    send_operand(8'h44, 8'h00, 4'b0000, 32'h0, 2);
    send_operand(8'h80, 8'h00, 4'b0000, 32'hAABB_CCDD, 3);
    // Stray bytes while idle.
    send_operand(8'hD1, 8'h00, 4'b0100, 32'h0, 0);
    send_byte(8'hAA, 1'b0, 4'b1111);
    send_byte(8'h55, 1'b0, 4'b0000);
    // Frame base with zero disp8, and the longest operand with every REX bit set.
    send_operand(8'h45, 8'h00, 4'b0001, 32'h0000_0000, 0);
    send_operand(8'h94, 8'hFF, 4'b1111, 32'h8000_0000, 0);

    // Random part: mostly complete operands, some truncated, some strays.
    bytes_sent = 0;
    while (bytes_sent < 1100) begin
      if ($urandom_range(0, 79) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        random_operand(0);
      end else if (r < 92) begin
        random_operand($urandom_range(1, 5));
      end else begin
        send_byte(8'($urandom), 1'b0, 4'($urandom));
      end
    end

    // Drain the outstanding operands, then watch a few more cycles.
    bytes_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
